FILE: src/phts_pkg.sv
// ----------------------------------------------------------------------------
// phts_pkg
// Shared types, codes and constants for the path health table selector.
// ----------------------------------------------------------------------------
package phts_pkg;

    localparam int PATH_SLOTS_DEF = 64;
    localparam int PEER_BITS_DEF  = 8;

    localparam logic [2:0] OP_REGISTER = 3'd0;
    localparam logic [2:0] OP_UPDATE   = 3'd1;
    localparam logic [2:0] OP_FAIL     = 3'd2;
    localparam logic [2:0] OP_SELECT   = 3'd3;
    localparam logic [2:0] OP_TICK     = 3'd4;
    localparam logic [2:0] OP_EVALUATE = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_PATH = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NO_SLOT = 2'd3;

    localparam logic [2:0] STRAT_LATENCY    = 3'd0;
    localparam logic [2:0] STRAT_THROUGHPUT = 3'd1;
    localparam logic [2:0] STRAT_BALANCED   = 3'd2;
    localparam logic [2:0] STRAT_COST       = 3'd3;

    localparam logic [0:0] CFG_FAILURE_LIMIT    = 1'd0;
    localparam logic [0:0] CFG_RECOVERY_SECONDS = 1'd1;

    localparam int CFG_DATA_W = 16;
    localparam int SCORE_W    = 25;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  peer;
        logic [5:0]  slot;
        logic [7:0]  hop_peer;
        logic [31:0] hop_address;
        logic [15:0] hop_port;
        logic [15:0] latency;
        logic [23:0] bandwidth;
        logic [2:0]  strategy;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  chosen_slot;
        logic [7:0]  out_hop_peer;
        logic [31:0] out_hop_address;
        logic [15:0] out_hop_port;
        logic [15:0] out_latency;
        logic [23:0] out_bandwidth;
        logic [24:0] score;
    } out_item_t;

    // scoring for one slot, units of 1/2000
    function automatic logic [SCORE_W-1:0] score_of(
        input logic [2:0]  strategy,
        input logic [15:0] lat,
        input logic [23:0] bw
    );
        logic [23:0] d2;
        logic [23:0] d1;
        logic [24:0] lp;
        begin
            d2 = 24'(lat) * 24'd200;
            d1 = 24'(lat) * 24'd100;
            lp = (d1 >= 24'd100000) ? 25'd0 : 25'(24'd100000 - d1);
            case (strategy)
                STRAT_LATENCY:
                    score_of = (d2 >= 24'd200000) ? '0 : 25'(24'd200000 - d2);
                STRAT_THROUGHPUT: score_of = {bw, 1'b0};
                STRAT_BALANCED:   score_of = lp + 25'(bw);
                STRAT_COST:       score_of = 25'd180000;
                default:          score_of = 25'd200000;
            endcase
        end
    endfunction

endpackage

FILE: src/phts_stream_if.sv
// ----------------------------------------------------------------------------
// phts_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface phts_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/phts_table.sv
// ----------------------------------------------------------------------------
// phts_table
// Path entry storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module phts_table
    import phts_pkg::*;
#(
    parameter int PATH_SLOTS = PATH_SLOTS_DEF,
    parameter int PEER_BITS  = PEER_BITS_DEF,
    localparam int SW = $clog2(PATH_SLOTS),
    localparam int EW = PEER_BITS + 8 + 32 + 16 + 16 + 24 + 4 + 1 + 32
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [SW-1:0] waddr,
    input  logic [EW-1:0] wdata,
    input  logic [SW-1:0] raddr,
    output logic [EW-1:0] rdata
);
    logic [EW-1:0] mem [PATH_SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: src/path_health_table_selector_unit.sv
// ----------------------------------------------------------------------------
// path_health_table_selector_unit
// Path health table selector. Each item takes one operation and yields one
// result beat. Register, update, mark failed, tick and the spare op codes
// present their result beat after a memory read state and then a modify and
// write-back state. Select and evaluate walk the table through the single
// memory read port one slot per cycle. Select presents its result when the
// scan ends, and evaluate after the scan and then the modify state. Once the
// result beat is accepted the block returns to idle, where it takes the next
// item. The block takes no new item until the result beat is accepted.
// There is no clearing pass after reset, because slot validity is kept in
// flip-flops.
// ----------------------------------------------------------------------------
module path_health_table_selector_unit
    import phts_pkg::*;
#(
    parameter int PATH_SLOTS = PATH_SLOTS_DEF,
    parameter int PEER_BITS  = PEER_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    phts_stream_if.sink           in_item,
    phts_stream_if.source         out_item
);
    localparam int SW = $clog2(PATH_SLOTS);
    localparam int CW = SW + 1;
    localparam int EW = PEER_BITS + 8 + 32 + 16 + 16 + 24 + 4 + 1 + 32;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_MOD  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    typedef struct packed {
        logic [PEER_BITS-1:0] owner;
        logic [7:0]  hop_peer;
        logic [31:0] hop_address;
        logic [15:0] hop_port;
        logic [15:0] lat;
        logic [23:0] bw;
        logic [3:0]  fails;
        logic        usable;
        logic [31:0] last_sec;
    } entry_t;

    logic [2:0]            state_reg;
    logic [3:0]            limit_reg;
    logic [15:0]           recov_reg;
    logic [31:0]           now_reg;
    logic [CW-1:0]         free_reg;
    logic [PATH_SLOTS-1:0] valid_reg;
    in_item_t              item_reg;
    out_item_t             res_reg;
    logic [CW-1:0]         idx_reg;    // slot issued to the read port
    logic [SW-1:0]         cur_reg;    // slot whose data is on rdata
    logic                  cur_v_reg;
    logic                  found_reg;
    logic [SW-1:0]         best_reg;
    logic [SCORE_W-1:0]    best_sc_reg;
    entry_t                best_e_reg;

    logic          we;
    logic [SW-1:0] waddr, raddr;
    entry_t        wentry, rentry;
    logic [EW-1:0] rdata;

    assign rentry = entry_t'(rdata);

    phts_table #(.PATH_SLOTS(PATH_SLOTS), .PEER_BITS(PEER_BITS)) u_table (
        .clk(clk), .we(we), .waddr(waddr), .wdata(EW'(wentry)),
        .raddr(raddr), .rdata(rdata)
    );

    assign in_item.ready = (state_reg == S_IDLE);
    assign out_item.valid = (state_reg == S_OUT);
    assign out_item.data = res_reg;

    logic [SW-1:0]        slot_ix;
    logic                 slot_ok;
    logic [PEER_BITS-1:0] peer_m;
    logic                 cand;
    logic [SCORE_W-1:0]   sc;
    logic [17:0]          lat3;
    logic [25:0]          bw3;
    logic [3:0]           fails_inc;
    logic                 scan_op;

    assign slot_ix = SW'(item_reg.slot);
    assign slot_ok = (32'(item_reg.slot) < 32'(PATH_SLOTS)) && valid_reg[slot_ix];
    assign peer_m  = PEER_BITS'(item_reg.peer);
    assign scan_op = (item_reg.op == OP_SELECT) || (item_reg.op == OP_EVALUATE);
    assign cand = cur_v_reg && valid_reg[cur_reg] && (rentry.owner == peer_m)
                  && rentry.usable && (rentry.fails < limit_reg);
    assign sc = score_of(item_reg.strategy, rentry.lat, rentry.bw);
    assign lat3 = 18'(rentry.lat) * 18'd3 + 18'(item_reg.latency);
    assign bw3  = 26'(rentry.bw) * 26'd3 + 26'(item_reg.bandwidth);
    assign fails_inc = (rentry.fails == 4'hF) ? 4'hF : rentry.fails + 4'd1;

    always_comb
    begin
        we = 1'b0;
        waddr = slot_ix;
        wentry = rentry;
        if (state_reg == S_IDLE)
            raddr = SW'(in_item.data.slot);
        else if (scan_op)
            raddr = SW'(idx_reg);
        else
            raddr = slot_ix;
        if (state_reg == S_MOD)
        begin
            case (item_reg.op)
                OP_REGISTER:
                begin
                    we = (free_reg < CW'(PATH_SLOTS));
                    waddr = SW'(free_reg);
                    wentry.owner = peer_m;
                    wentry.hop_peer = item_reg.hop_peer;
                    wentry.hop_address = item_reg.hop_address;
                    wentry.hop_port = item_reg.hop_port;
                    wentry.lat = item_reg.latency;
                    wentry.bw = item_reg.bandwidth;
                    wentry.fails = 4'd0;
                    wentry.usable = 1'b1;
                    wentry.last_sec = now_reg;
                end
                OP_UPDATE:
                begin
                    we = slot_ok;
                    wentry.lat = lat3[17:2];
                    wentry.bw = bw3[25:2];
                    wentry.fails = 4'd0;
                    wentry.usable = 1'b1;
                    wentry.last_sec = now_reg;
                end
                OP_FAIL:
                begin
                    we = slot_ok;
                    wentry.fails = fails_inc;
                    if (fails_inc >= limit_reg)
                    begin
                        wentry.usable = 1'b0;
                    end
                end
                default: ;
            endcase
        end
        else if (state_reg == S_SCAN && item_reg.op == OP_EVALUATE)
        begin
            waddr = cur_reg;
            we = cur_v_reg && valid_reg[cur_reg] && !rentry.usable
                 && ((now_reg - rentry.last_sec) > 32'(recov_reg));
            wentry.fails = 4'd0;
            wentry.usable = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            limit_reg   <= 4'd3;
            recov_reg   <= 16'd60;
            now_reg     <= '0;
            free_reg    <= '0;
            valid_reg   <= '0;
            cur_v_reg   <= 1'b0;
            found_reg   <= 1'b0;
            item_reg    <= '0;
            res_reg     <= '0;
            idx_reg     <= '0;
            cur_reg     <= '0;
            best_reg    <= '0;
            best_sc_reg <= '0;
            best_e_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_FAILURE_LIMIT)
                    limit_reg <= cfg_data[3:0];
                else
                    recov_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_item.valid)
                    begin
                        item_reg  <= in_item.data;
                        res_reg   <= '0;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        cur_v_reg <= 1'b0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    if (scan_op)
                    begin
                        // slot 0 is issued to the read port in this cycle
                        cur_reg   <= SW'(idx_reg);
                        cur_v_reg <= 1'b1;
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_SCAN;
                    end
                    else
                        state_reg <= S_MOD;
                end
                S_MOD:
                begin
                    state_reg <= S_OUT;
                    case (item_reg.op)
                        OP_REGISTER:
                        begin
                            if (free_reg < CW'(PATH_SLOTS))
                            begin
                                valid_reg[SW'(free_reg)] <= 1'b1;
                                free_reg <= free_reg + CW'(1);
                                res_reg <= {ST_OK, 6'(free_reg), item_reg.hop_peer,
                                    item_reg.hop_address, item_reg.hop_port,
                                    item_reg.latency, item_reg.bandwidth,
                                    25'd0};
                            end
                            else
                                res_reg.status <= ST_FULL;
                        end
                        OP_UPDATE, OP_FAIL:
                        begin
                            if (slot_ok)
                                res_reg <= {ST_OK, item_reg.slot, rentry.hop_peer,
                                    rentry.hop_address, rentry.hop_port,
                                    wentry.lat, wentry.bw, 25'd0};
                            else
                                res_reg.status <= ST_NO_SLOT;
                        end
                        OP_TICK: now_reg <= now_reg + 32'd1;
                        default: ;
                    endcase
                end
                S_SCAN:
                begin
                    // data for cur_reg is on rdata now
                    if (item_reg.op == OP_SELECT && cand
                        && (!found_reg || sc > best_sc_reg))
                    begin
                        found_reg   <= 1'b1;
                        best_reg    <= cur_reg;
                        best_sc_reg <= sc;
                        best_e_reg  <= rentry;
                    end
                    if (32'(cur_reg) == PATH_SLOTS - 1)
                    begin
                        cur_v_reg <= 1'b0;
                        state_reg <= (item_reg.op == OP_SELECT) ? S_OUT : S_MOD;
                    end
                    else
                    begin
                        cur_reg <= SW'(idx_reg);
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                S_OUT:
                begin
                    if (out_item.ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
            // select result is built on the way out of the scan
            if (state_reg == S_SCAN && item_reg.op == OP_SELECT
                && 32'(cur_reg) == PATH_SLOTS - 1)
            begin
                if (cand && (!found_reg || sc > best_sc_reg))
                    res_reg <= {ST_OK, 6'(cur_reg), rentry.hop_peer,
                        rentry.hop_address, rentry.hop_port, rentry.lat,
                        rentry.bw, sc};
                else if (found_reg)
                    res_reg <= {ST_OK, 6'(best_reg), best_e_reg.hop_peer,
                        best_e_reg.hop_address, best_e_reg.hop_port,
                        best_e_reg.lat, best_e_reg.bw, best_sc_reg};
                else
                    res_reg <= {ST_NO_PATH, 127'd0};
            end
        end
    end

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_item.valid |-> !in_item.ready)
        else $error("ready while result pending");
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= CW'(PATH_SLOTS))
        else $error("free pointer beyond table");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_item.valid && !out_item.ready |=> out_item.valid && $stable(res_reg))
        else $error("result changed while stalled");
`endif
endmodule

FILE: dv/tb_path_health_table_selector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_path_health_table_selector_unit
// Self-checking bench for the path health table selector: directed beats for
// each operation and corner, then weighted random traffic over several
// threshold settings, with random gaps on the input channel and back-pressure on the output channel.
// ----------------------------------------------------------------------------
module tb_path_health_table_selector_unit;
    import phts_pkg::*;

    localparam int SLOTS       = 64;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_BEATS = 250;

    class path_table_sb;
        logic        valid_q   [SLOTS];
        logic [7:0]  owner_q   [SLOTS];
        logic [7:0]  hop_peer_q[SLOTS];
        logic [31:0] hop_addr_q[SLOTS];
        logic [15:0] hop_port_q[SLOTS];
        logic [15:0] lat_q     [SLOTS];
        logic [23:0] bw_q      [SLOTS];
        logic [3:0]  fails_q   [SLOTS];
        logic        usable_q  [SLOTS];
        logic [31:0] last_q    [SLOTS];
        logic [31:0] now_s;
        int          fill;
        logic [3:0]  fail_limit;
        logic [15:0] recover_s;
        out_item_t   expected_beats[$];
        int          errors;
        int          checked;
        int          selects_hit;

        function new();
            for (int i = 0; i < SLOTS; i++)
                valid_q[i] = 1'b0;
            now_s       = '0;
            fill        = 0;
            fail_limit  = 4'd3;
            recover_s   = 16'd60;
            errors      = 0;
            checked     = 0;
            selects_hit = 0;
        endfunction

        function void set_reg(logic [0:0] idx, logic [15:0] val);
            if (idx == CFG_FAILURE_LIMIT)
                fail_limit = val[3:0];
            else
                recover_s = val;
        endfunction

        function logic [24:0] path_score(int s, logic [2:0] strat);
            int unsigned d;
            case (strat)
                STRAT_LATENCY:
                begin
                    d = 200 * lat_q[s];
                    return (d >= 200000) ? 25'd0 : 25'(200000 - d);
                end
                STRAT_THROUGHPUT: return 25'(2 * int'(bw_q[s]));
                STRAT_BALANCED:
                begin
                    d = 100 * lat_q[s];
                    return 25'(((d >= 100000) ? 0 : 100000 - d) + bw_q[s]);
                end
                STRAT_COST: return 25'd180000;
                default:    return 25'd200000;
            endcase
        endfunction

        function out_item_t entry_beat(int s, logic [24:0] sc);
            out_item_t r;
            r.status          = ST_OK;
            r.chosen_slot     = s[5:0];
            r.out_hop_peer    = hop_peer_q[s];
            r.out_hop_address = hop_addr_q[s];
            r.out_hop_port    = hop_port_q[s];
            r.out_latency     = lat_q[s];
            r.out_bandwidth   = bw_q[s];
            r.score           = sc;
            return r;
        endfunction

        function void note_input(in_item_t it);
            out_item_t   r;
            int          s;
            int          best;
            logic [24:0] sc;
            logic [24:0] best_sc;
            r    = '0;
            best = -1;
            best_sc = '0;
            s    = it.slot;
            case (it.op)
                OP_REGISTER:
                begin
                    if (fill >= SLOTS)
                        r.status = ST_FULL;
                    else
                    begin
                        valid_q[fill]    = 1'b1;
                        owner_q[fill]    = it.peer;
                        hop_peer_q[fill] = it.hop_peer;
                        hop_addr_q[fill] = it.hop_address;
                        hop_port_q[fill] = it.hop_port;
                        lat_q[fill]      = it.latency;
                        bw_q[fill]       = it.bandwidth;
                        fails_q[fill]    = '0;
                        usable_q[fill]   = 1'b1;
                        last_q[fill]     = now_s;
                        r = entry_beat(fill, '0);
                        fill++;
                    end
                end
                OP_UPDATE, OP_FAIL:
                begin
                    if (!valid_q[s])
                        r.status = ST_NO_SLOT;
                    else
                    begin
                        if (it.op == OP_UPDATE)
                        begin
                            lat_q[s]    = 16'((3 * int'(lat_q[s]) + it.latency) / 4);
                            bw_q[s]     = 24'((3 * int'(bw_q[s]) + it.bandwidth) / 4);
                            fails_q[s]  = '0;
                            usable_q[s] = 1'b1;
                            last_q[s]   = now_s;
                        end
                        else
                        begin
                            if (fails_q[s] != 4'hF)
                                fails_q[s] = fails_q[s] + 4'd1;
                            if (fails_q[s] >= fail_limit)
                                usable_q[s] = 1'b0;
                        end
                        r = entry_beat(s, '0);
                    end
                end
                OP_SELECT:
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (valid_q[i] && owner_q[i] == it.peer && usable_q[i] &&
                            fails_q[i] < fail_limit)
                        begin
                            sc = path_score(i, it.strategy);
                            if (best < 0 || sc > best_sc)
                            begin
                                best    = i;
                                best_sc = sc;
                            end
                        end
                    end
                    if (best < 0)
                        r.status = ST_NO_PATH;
                    else
                    begin
                        r = entry_beat(best, best_sc);
                        selects_hit++;
                    end
                end
                OP_TICK: now_s = now_s + 32'd1;
                OP_EVALUATE:
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (valid_q[i] && !usable_q[i] && (now_s - last_q[i]) > recover_s)
                        begin
                            fails_q[i]  = '0;
                            usable_q[i] = 1'b1;
                        end
                end
                default: ;
            endcase
            expected_beats.insert(expected_beats.size(), r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch %0s: got 0x%0h want 0x%0h (beat %0d)", what, got, want,
                     checked);
        endtask

        task check_result(out_item_t got);
            out_item_t w;
            if (expected_beats.size() == 0)
            begin
                report("unexpected beat", got.status, 0);
                return;
            end
            w = expected_beats.pop_front();
            if (got.status != w.status) report("status", got.status, w.status);
            if (got.chosen_slot != w.chosen_slot)
                report("chosen_slot", got.chosen_slot, w.chosen_slot);
            if (got.out_hop_peer != w.out_hop_peer)
                report("out_hop_peer", got.out_hop_peer, w.out_hop_peer);
            if (got.out_hop_address != w.out_hop_address)
                report("out_hop_address", got.out_hop_address, w.out_hop_address);
            if (got.out_hop_port != w.out_hop_port)
                report("out_hop_port", got.out_hop_port, w.out_hop_port);
            if (got.out_latency != w.out_latency)
                report("out_latency", got.out_latency, w.out_latency);
            if (got.out_bandwidth != w.out_bandwidth)
                report("out_bandwidth", got.out_bandwidth, w.out_bandwidth);
            if (got.score != w.score) report("score", got.score, w.score);
            checked++;
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [0:0]       cfg_index;
    logic [15:0]      cfg_data;
    int               cycles;
    bit               no_idle;
    path_table_sb     sb;

    phts_stream_if #(.payload_t(in_item_t))  in_ch();
    phts_stream_if #(.payload_t(out_item_t)) out_ch();

    path_health_table_selector_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_ch),
        .out_item  (out_ch)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
        if (out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.data);

    // sink side: random stall before each beat
    initial
    begin
        int n;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = no_idle ? 0 : $urandom_range(0, 5);
            if (n > 0)
            begin
                out_ch.ready = 1'b0;
                repeat (n) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.expected_beats.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_beat(in_item_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data  = it;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_input(it);
        @(negedge clk);
    endtask

    function automatic in_item_t rand_beat();
        in_item_t it;
        int       w;
        it.op          = 3'($urandom_range(0, 7));
        it.peer        = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        it.slot        = ($urandom_range(0, 4) == 0 || sb.fill == 0) ? 6'($urandom)
                                                   : 6'($urandom_range(0, sb.fill - 1));
        it.hop_peer    = 8'($urandom);
        it.hop_address = $urandom;
        it.hop_port    = 16'($urandom);
        it.latency     = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 1200));
        it.bandwidth   = 24'($urandom);
        it.strategy    = 3'($urandom_range(0, 7));
        w = $urandom_range(0, 99);
        if (w < 14)      it.op = OP_REGISTER;
        else if (w < 34) it.op = OP_UPDATE;
        else if (w < 56) it.op = OP_FAIL;
        else if (w < 80) it.op = OP_SELECT;
        else if (w < 90) it.op = OP_TICK;
        else if (w < 97) it.op = OP_EVALUATE;
        return it;
    endfunction

    function automatic in_item_t mk(logic [2:0] op, logic [7:0] peer, logic [5:0] slot,
                                    logic [15:0] lat, logic [23:0] bw, logic [2:0] strat);
        in_item_t it;
        it             = '0;
        it.op          = op;
        it.peer        = peer;
        it.slot        = slot;
        it.latency     = lat;
        it.bandwidth   = bw;
        it.strategy    = strat;
        it.hop_peer    = 8'($urandom);
        it.hop_address = $urandom;
        it.hop_port    = 16'($urandom);
        return it;
    endfunction

    initial
    begin
        in_item_t it;
        logic [3:0]  lim_set [4];
        logic [15:0] rec_set [4];
        sb          = new();
        cycles      = 0;
        no_idle     = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: corners of each operation at reset thresholds
        it = mk(OP_REGISTER, 8'd0, 6'd0, 16'd0, 24'hFFFFFF, 3'd0);
        it.hop_peer = 8'hFF; it.hop_address = 32'hFFFFFFFF; it.hop_port = 16'hFFFF;
        send_beat(it);
        it = mk(OP_REGISTER, 8'hFF, 6'd0, 16'hFFFF, 24'd0, 3'd0);
        it.hop_peer = '0; it.hop_address = '0; it.hop_port = '0;
        send_beat(it);
        send_beat(mk(OP_REGISTER, 8'd0, 6'd0, 16'd500, 24'd1000, 3'd0));
        for (int s = 0; s < 8; s++)
            send_beat(mk(OP_SELECT, 8'd0, 6'd0, 16'd0, 24'd0, 3'(s)));
        send_beat(mk(OP_SELECT, 8'd7, 6'd0, 16'd0, 24'd0, 3'd0));
        send_beat(mk(OP_UPDATE, 8'd0, 6'd63, 16'd1, 24'd1, 3'd0));
        send_beat(mk(OP_FAIL, 8'd0, 6'd63, 16'd0, 24'd0, 3'd0));
        send_beat(mk(OP_UPDATE, 8'd0, 6'd2, 16'hFFFF, 24'hFFFFFF, 3'd0));
        repeat (3) send_beat(mk(OP_FAIL, 8'd0, 6'd1, 16'd0, 24'd0, 3'd0));
        send_beat(mk(OP_SELECT, 8'hFF, 6'd0, 16'd0, 24'd0, 3'd1));
        send_beat(mk(OP_TICK, 8'd0, 6'd0, 16'd0, 24'd0, 3'd0));
        send_beat(mk(OP_EVALUATE, 8'd0, 6'd0, 16'd0, 24'd0, 3'd0));
        send_beat(mk(3'd6, 8'd0, 6'd0, 16'd0, 24'd0, 3'd0));
        send_beat(mk(3'd7, 8'd0, 6'd0, 16'd0, 24'd0, 3'd0));
        in_ch.valid = 1'b0;
        wait_drained();

        // random phases across threshold settings, extremes included
        lim_set = '{4'd1, 4'd15, 4'd2, 4'($urandom_range(1, 15))};
        rec_set = '{16'd0, 16'hFFFF, 16'd3, 16'($urandom_range(0, 20))};
        for (int p = 0; p < 4; p++)
        begin
            write_reg(CFG_FAILURE_LIMIT, {12'd0, lim_set[p]});
            write_reg(CFG_RECOVERY_SECONDS, rec_set[p]);
            for (int n = 0; n < RANDOM_BEATS; n++)
            begin
                if (n % 60 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                send_beat(rand_beat());
            end
            in_ch.valid = 1'b0;
            no_idle     = 1'b0;
            wait_drained();
        end

        repeat (80) @(negedge clk);
        $display("covered %0d result beats over 4 threshold settings, %0d of %0d slots filled",
                 sb.checked, sb.fill, SLOTS);
        $display("%0d selects found a path, %0d mismatches", sb.selects_hit, sb.errors);
        if (sb.errors == 0 && sb.expected_beats.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
